[rtl/fsns_pkg.sv]
// Shared types, constants and selection helpers for the free-state search.
`timescale 1ns / 1ps

package fsns_pkg;

  localparam int STATE_COUNT = 8;  // lanes actually built, 2..8
  localparam int COUNT_BITS  = 8;  // used bits of each packed count, 4..8
  localparam int STATE_IDX_W = 3;  // fixed by the state index fields
  localparam int STATE_SPAN  = 1 << STATE_IDX_W;
  localparam int NACT_W      = STATE_IDX_W + 1;
  localparam int LOAD_W      = COUNT_BITS + 1;
  localparam int PACK_W      = 64;
  localparam int BYTE_W      = 8;

  // Configuration register indexes.
  typedef enum logic {
    CFG_STATES_IN_USE = 1'b0,
    CFG_CPU_COUNTS    = 1'b1
  } cfg_idx_t;

  // Search modes.
  typedef enum logic [1:0] {
    MODE_DOWN    = 2'd0,
    MODE_UP      = 2'd1,
    MODE_CLOSEST = 2'd2,
    MODE_LEAST   = 2'd3
  } mode_t;

  typedef struct packed {
    logic              free;
    logic              has_cpu;
    logic [LOAD_W-1:0] load;     // tasks + 2^COUNT_BITS - cpus
  } lane_res_t;

  typedef struct packed {
    logic                   hit;
    logic [STATE_IDX_W-1:0] idx;
  } sel_t;

  // One node of the least-loaded min tree.
  typedef struct packed {
    logic                   hit;
    logic [LOAD_W-1:0]      load;
    logic [STATE_IDX_W-1:0] idx;
  } ll_node_t;

  // Lowest set bit.
  function automatic sel_t pri_low(input logic [STATE_SPAN-1:0] v);
    sel_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int s = STATE_SPAN - 1; s >= 0; s--) begin
      if (v[s]) begin
        r.hit = 1'b1;
        r.idx = STATE_IDX_W'(s);
      end
    end
    return r;
  endfunction

  // Highest set bit.
  function automatic sel_t pri_high(input logic [STATE_SPAN-1:0] v);
    sel_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int s = 0; s < STATE_SPAN; s++) begin
      if (v[s]) begin
        r.hit = 1'b1;
        r.idx = STATE_IDX_W'(s);
      end
    end
    return r;
  endfunction

  // Smaller load of two nodes; lo holds the lower indexes and keeps ties.
  function automatic ll_node_t ll_pick(input ll_node_t lo, input ll_node_t hi);
    if (hi.hit && (!lo.hit || (hi.load < lo.load))) return hi;
    return lo;
  endfunction

endpackage

[rtl/fsns_lane.sv]
// One per-state lane: free test and load for a single performance state.
`timescale 1ns / 1ps

module fsns_lane
  import fsns_pkg::*;
(
  input  logic                  clk,
  input  logic                  in_use,     // state index below active count
  input  logic                  is_old,     // state is the task's old state
  input  logic [COUNT_BITS-1:0] cpu_count,
  input  logic [COUNT_BITS-1:0] task_count,
  input  logic [COUNT_BITS-1:0] old_count,  // old state's count without the task
  output lane_res_t             res
);

  logic [COUNT_BITS-1:0] cpus;
  lane_res_t             res_nxt;
  lane_res_t             res_r;

  always_comb begin
    cpus             = in_use ? cpu_count : '0;
    res_nxt.has_cpu  = (cpus != '0);
    res_nxt.free     = res_nxt.has_cpu &&
                       ((is_old && (old_count < cpus)) || (task_count < cpus));
    res_nxt.load     = {1'b0, task_count} - {1'b0, cpus}
                       + LOAD_W'(1 << COUNT_BITS);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

[rtl/fsns_merge.sv]
// Merge stage: priority scans, nearest pick and least-loaded fallback.
`timescale 1ns / 1ps

module fsns_merge
  import fsns_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid,
  input  logic [1:0]                         mode,
  input  logic [STATE_IDX_W-1:0]             target_state,
  input  lane_res_t [STATE_COUNT-1:0]        lane_res,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [STATE_IDX_W-1:0]             out_chosen_state
);

  logic [STATE_SPAN-1:0]  free_v, has_v, le_m, lt_m, ge_m, gt_m;
  sel_t                   hi_le, hi_lt, lo_ge, lo_gt;
  sel_t                   down_sel, up_sel, near_sel, scan_sel;
  sel_t                   ll_sel;
  ll_node_t               ll_l0 [STATE_SPAN];
  ll_node_t               ll_l1 [STATE_SPAN/2];
  ll_node_t               ll_l2 [STATE_SPAN/4];
  ll_node_t               ll_root;
  logic [STATE_IDX_W-1:0] dist_dn, dist_up;
  logic                   found_nxt;
  logic [STATE_IDX_W-1:0] chosen_nxt;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [STATE_IDX_W-1:0] out_chosen_r;

  always_comb begin
    free_v = '0;
    has_v  = '0;
    for (int s = 0; s < STATE_COUNT; s++) begin
      free_v[s] = lane_res[s].free;
      has_v[s]  = lane_res[s].has_cpu;
    end
    for (int s = 0; s < STATE_SPAN; s++) begin
      le_m[s] = (STATE_IDX_W'(s) <= target_state);
      lt_m[s] = (STATE_IDX_W'(s) <  target_state);
      ge_m[s] = (STATE_IDX_W'(s) >= target_state);
      gt_m[s] = (STATE_IDX_W'(s) >  target_state);
    end

    hi_le = pri_high(free_v & le_m);
    hi_lt = pri_high(free_v & lt_m);
    lo_ge = pri_low(free_v & ge_m);
    lo_gt = pri_low(free_v & gt_m);

    down_sel = hi_le.hit ? hi_le : lo_gt;
    up_sel   = lo_ge.hit ? lo_ge : hi_lt;

    // Nearest free state; equal distance goes to the upper one.
    dist_dn = target_state - hi_lt.idx;
    dist_up = lo_gt.idx - target_state;
    if (free_v[target_state]) begin
      near_sel.hit = 1'b1;
      near_sel.idx = target_state;
    end else if (hi_lt.hit && lo_gt.hit) begin
      near_sel = (dist_dn < dist_up) ? hi_lt : lo_gt;
    end else if (hi_lt.hit) begin
      near_sel = hi_lt;
    end else begin
      near_sel = lo_gt;
    end

    // Least loaded as a three-level min tree, lowest index on ties.
    for (int s = 0; s < STATE_SPAN; s++) begin
      ll_l0[s].hit  = 1'b0;
      ll_l0[s].load = '0;
      ll_l0[s].idx  = STATE_IDX_W'(s);
    end
    for (int s = 0; s < STATE_COUNT; s++) begin
      ll_l0[s].hit  = has_v[s];
      ll_l0[s].load = lane_res[s].load;
    end
    for (int s = 0; s < STATE_SPAN / 2; s++) begin
      ll_l1[s] = ll_pick(ll_l0[2*s], ll_l0[2*s+1]);
    end
    for (int s = 0; s < STATE_SPAN / 4; s++) begin
      ll_l2[s] = ll_pick(ll_l1[2*s], ll_l1[2*s+1]);
    end
    ll_root    = ll_pick(ll_l2[0], ll_l2[1]);
    ll_sel.hit = ll_root.hit;
    ll_sel.idx = ll_root.idx;

    unique case (mode)
      MODE_DOWN:    scan_sel = down_sel;
      MODE_UP:      scan_sel = up_sel;
      MODE_CLOSEST: scan_sel = near_sel;
      MODE_LEAST:   scan_sel = '0;
      default:      scan_sel = '0;
    endcase

    if (scan_sel.hit) begin
      found_nxt  = 1'b1;
      chosen_nxt = scan_sel.idx;
    end else begin
      found_nxt  = ll_sel.hit;
      chosen_nxt = ll_sel.hit ? ll_sel.idx : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= found_nxt;
    out_chosen_r <= chosen_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_chosen_state = out_chosen_r;

endmodule

[rtl/free_state_nearest_search.sv]
// Top level of the free-state nearest search: config registers, lanes, merge.
`timescale 1ns / 1ps

// Picks a performance state for a task, one item per clock. An item is taken
// at any edge with start high; busy never rises, since nothing is shared
// between items. The result shows on out_found / out_chosen_state for exactly
// one cycle with out_valid high. The per-state lane registers capture at the
// accepting edge, then the merge-stage output registers capture the result.
// The receiver cannot stall, so results must be taken as they come.
// Write states_in_use and cpu_counts over the cfg_ port only while no item is
// in flight; writes take effect on the next edge.

module free_state_nearest_search
  import fsns_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // config write port
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [PACK_W-1:0]      cfg_wdata,
  // item in
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_mode,
  input  logic [STATE_IDX_W-1:0] in_cur_state,
  input  logic [STATE_IDX_W-1:0] in_target_state,
  input  logic [PACK_W-1:0]      in_task_counts,
  input  logic [BYTE_W-1:0]      in_old_count_without_self,
  // result out
  output logic                   out_valid,
  output logic                   out_found,
  output logic [STATE_IDX_W-1:0] out_chosen_state
);

  localparam logic [NACT_W-1:0] STATES_MAX = NACT_W'(STATE_COUNT);

  // Config registers
  logic [NACT_W-1:0]      states_in_use_r;
  logic [PACK_W-1:0]      cpu_counts_r;
  logic [NACT_W-1:0]      n_act;

  // Item control along the lane stage
  logic                   accept;
  logic                   v1_r;
  logic [1:0]             mode_r;
  logic [STATE_IDX_W-1:0] target_r;

  lane_res_t [STATE_COUNT-1:0] lane_res;

  assign busy   = 1'b0;       // fully pipelined, always ready
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_in_use_r <= NACT_W'(8);
      cpu_counts_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATES_IN_USE: states_in_use_r <= cfg_wdata[NACT_W-1:0];
        CFG_CPU_COUNTS:    cpu_counts_r    <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  // Counts above the built lanes act as all lanes.
  assign n_act = (states_in_use_r > STATES_MAX) ? STATES_MAX : states_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= in_mode;
    target_r <= in_target_state;
  end

  // One lane per state; each registers its free flag and load.
  for (genvar s = 0; s < STATE_COUNT; s++) begin : g_lane
    fsns_lane u_lane (
      .clk        (clk),
      .in_use     (NACT_W'(s) < n_act),
      .is_old     (in_cur_state == STATE_IDX_W'(s)),
      .cpu_count  (cpu_counts_r[BYTE_W*s +: COUNT_BITS]),
      .task_count (in_task_counts[BYTE_W*s +: COUNT_BITS]),
      .old_count  (in_old_count_without_self[COUNT_BITS-1:0]),
      .res        (lane_res[s])
    );
  end

  fsns_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid            (v1_r),
    .mode             (mode_r),
    .target_state     (target_r),
    .lane_res         (lane_res),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_chosen_state (out_chosen_state)
  );

  // Every result comes from an item that was in the lane stage in the previous cycle.
  a_out_from_lane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v1_r))
    else $error("result without item in lane stage");

  // An item in the lane stage always yields a result next cycle.
  a_lane_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> out_valid)
    else $error("item lost between lane and merge stage");

  // Not-found results carry state zero.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_chosen_state == '0))
    else $error("not-found result with nonzero state");

endmodule
